// ----- sv/vsa_pkg.sv -----
// shared constants for the two-class virtual channel switch allocator
// no dependencies
package vsa_pkg;

  // starvation counter and limit register width
  localparam int unsigned CNT_W = 8;

  // starvation limit after reset
  localparam logic [CNT_W-1:0] STARVE_LIMIT_RST = 8'd8;

endpackage

// ----- sv/vsa_rr_pick.sv -----
// round-robin pick over one class of virtual channels
// standalone, no package use
module vsa_rr_pick #(
  parameter int unsigned N     = 4,
  parameter int unsigned PTR_W = 2
) (
  input  logic [N-1:0]     req,
  input  logic [PTR_W-1:0] ptr,
  output logic             found,
  output logic [PTR_W-1:0] pos
);

  logic [N-1:0]     req_hi;
  logic [PTR_W-1:0] pos_hi;
  logic [PTR_W-1:0] pos_lo;

  // requests at or above the pointer come first
  always_comb begin
    for (int i = 0; i < N; i++) begin
      req_hi[i] = req[i] && (i >= int'(ptr));
    end
  end

  // lowest set bit at or above the pointer, and lowest set bit over all requests
  always_comb begin
    pos_hi = '0;
    pos_lo = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (req_hi[i]) begin
        pos_hi = PTR_W'(i);
      end
      if (req[i]) begin
        pos_lo = PTR_W'(i);
      end
    end
  end

  assign found = |req;
  assign pos   = (|req_hi) ? pos_hi : pos_lo;

endmodule

// ----- sv/vc_switch_allocator_two_class.sv -----
// two-class round-robin switch allocator for one router input port
// depends on vsa_pkg and vsa_rr_pick
//
//   channel | direction | contents
//   in_     | slave     | tdata: ready_mask, space_mask, tail_mask
//   out_    | master    | tdata: granted, granted_vc, release_vc; tuser: from_priority
//   cfg_    | write     | starve limit
//
// one transaction per cycle while the result is not stalled; the input register captures a transaction
// and the result register takes its grant when it advances, so out_tvalid rises once the result register loads
// pointers and starvation count update as each transaction moves into the result register
// reset (rst_n low, synchronous) clears pointers and count, limit returns to 8
// a stalled result holds; the input register still takes a transaction while it is empty,
// or while its content moves on into a draining or empty result register
module vc_switch_allocator_two_class #(
  parameter int unsigned NORMAL_VCS   = 4,
  parameter int unsigned PRIORITY_VCS = 2
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // ready_mask, space_mask, tail_mask from bit 0 up, zero pad to bytes
  input  logic [((3*(NORMAL_VCS+PRIORITY_VCS)+7)/8)*8-1:0] in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // granted, granted_vc, release_vc from bit 0 up, zero pad to bytes
  output logic [((2+$clog2(NORMAL_VCS+PRIORITY_VCS)+7)/8)*8-1:0] out_tdata,
  // from_priority
  output logic                                  out_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_we,
  input  logic [vsa_pkg::CNT_W-1:0]             cfg_wdata
);

  localparam int unsigned TOT_VCS = NORMAL_VCS + PRIORITY_VCS;
  localparam int unsigned VC_W    = $clog2(TOT_VCS);
  localparam int unsigned NP_W    = (NORMAL_VCS > 1) ? $clog2(NORMAL_VCS) : 1;
  localparam int unsigned PP_W    = (PRIORITY_VCS > 1) ? $clog2(PRIORITY_VCS) : 1;
  localparam int unsigned OUT_W   = ((2+VC_W+7)/8)*8;
  localparam int unsigned CW      = vsa_pkg::CNT_W;

  // input register
  logic               s1_valid_r;
  logic [TOT_VCS-1:0] ready_r, space_r, tail_r;

  // allocator state
  logic [NP_W-1:0] nrm_ptr_r, nrm_ptr_nxt;
  logic [PP_W-1:0] pri_ptr_r, pri_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   limit_r;

  // result register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_tdata_r, out_tdata_nxt;
  logic             out_tuser_r, out_tuser_nxt;

  logic               advance;
  logic [TOT_VCS-1:0] elig;
  logic               nrm_found, pri_found;
  logic [NP_W-1:0]    nrm_pos;
  logic [PP_W-1:0]    pri_pos;
  logic               skip, win_first, win_pri, granted;
  logic [VC_W-1:0]    win_vc;
  logic               release_vc;

  // handshake
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // capture transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ready_r <= in_tdata[TOT_VCS-1:0];
      space_r <= in_tdata[2*TOT_VCS-1:TOT_VCS];
      tail_r  <= in_tdata[3*TOT_VCS-1:2*TOT_VCS];
    end
  end

  assign elig = ready_r & space_r;

  vsa_rr_pick #(.N(NORMAL_VCS), .PTR_W(NP_W)) u_nrm_pick (
    .req   (elig[NORMAL_VCS-1:0]),
    .ptr   (nrm_ptr_r),
    .found (nrm_found),
    .pos   (nrm_pos)
  );

  vsa_rr_pick #(.N(PRIORITY_VCS), .PTR_W(PP_W)) u_pri_pick (
    .req   (elig[TOT_VCS-1:NORMAL_VCS]),
    .ptr   (pri_ptr_r),
    .found (pri_found),
    .pos   (pri_pos)
  );

  // winner selection: priority first unless starved, then normal, then priority fallback
  assign skip      = (cnt_r == limit_r);
  assign win_first = !skip && pri_found;
  assign win_pri   = pri_found && (!skip || !nrm_found);
  assign granted   = pri_found || nrm_found;

  always_comb begin
    win_vc = '0;
    if (win_pri) begin
      win_vc = VC_W'(NORMAL_VCS) + VC_W'(pri_pos);
    end else if (nrm_found) begin
      win_vc = VC_W'(nrm_pos);
    end
  end

  assign release_vc = granted && tail_r[win_vc];

  // next state of pointers and starvation count
  always_comb begin
    nrm_ptr_nxt = nrm_ptr_r;
    pri_ptr_nxt = pri_ptr_r;
    cnt_nxt     = cnt_r;
    if (skip) begin
      cnt_nxt = '0;
    end else if (win_first) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (win_pri) begin
      pri_ptr_nxt = (pri_ptr_r == PP_W'(PRIORITY_VCS - 1)) ? '0 : pri_ptr_r + PP_W'(1);
    end else if (nrm_found) begin
      nrm_ptr_nxt = (nrm_ptr_r == NP_W'(NORMAL_VCS - 1)) ? '0 : nrm_ptr_r + NP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_ptr_r <= '0;
      pri_ptr_r <= '0;
      cnt_r     <= '0;
    end else if (advance) begin
      nrm_ptr_r <= nrm_ptr_nxt;
      pri_ptr_r <= pri_ptr_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= vsa_pkg::STARVE_LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // result packing
  always_comb begin
    out_tdata_nxt             = '0;
    out_tdata_nxt[0]          = granted;
    out_tdata_nxt[VC_W:1]     = win_vc;
    out_tdata_nxt[VC_W+1]     = release_vc;
    out_tuser_nxt             = win_pri;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // checks
  a_vc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tdata_r[0] |-> (int'(out_tdata_r[VC_W:1]) < TOT_VCS))
    else $error("granted vc out of range");

  a_prio_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tuser_r |-> out_tdata_r[0]
      && (int'(out_tdata_r[VC_W:1]) >= NORMAL_VCS))
    else $error("priority flag on a non-priority winner");

  a_release_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tdata_r[VC_W+1] |-> out_tdata_r[0])
    else $error("release without grant");

  a_starve_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && skip |=> cnt_r == '0)
    else $error("starvation count not cleared at limit");

  a_one_ptr_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !(nrm_ptr_nxt != nrm_ptr_r && pri_ptr_nxt != pri_ptr_r))
    else $error("both class pointers advanced");

endmodule
